FILE: hdl/assert_macros.svh
// Assertion helpers, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/rpb_pkg.sv
package rpb_pkg;

    localparam int CNT_W   = 12;
    localparam int FIELD_W = 12;
    localparam int COORD_W = 14;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 18;
    localparam int ROT_W   = 2;

    localparam int PHYS_WIDTH_DEF  = 320;
    localparam int PHYS_HEIGHT_DEF = 480;

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      done;
        logic [PIX_W-1:0]          pixel;
    } t_coord;

endpackage

FILE: hdl/rpb_pix_if.sv
interface rpb_pix_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  start_of_area;
    logic signed [rpb_pkg::FIELD_W-1:0]    area_left;
    logic signed [rpb_pkg::FIELD_W-1:0]    area_top;
    logic signed [rpb_pkg::FIELD_W-1:0]    area_right;
    logic signed [rpb_pkg::FIELD_W-1:0]    area_bottom;
    logic [rpb_pkg::PIX_W-1:0]             pixel_in;

    modport source (
        output valid, start_of_area, area_left, area_top, area_right, area_bottom, pixel_in,
        input  ready
    );
    modport sink (
        input  valid, start_of_area, area_left, area_top, area_right, area_bottom, pixel_in,
        output ready
    );
endinterface

FILE: hdl/rpb_fb_if.sv
interface rpb_fb_if;
    logic                         valid;
    logic                         ready;
    logic                         write_enable;
    logic [rpb_pkg::ADDR_W-1:0]   fb_address;
    logic [rpb_pkg::PIX_W-1:0]    fb_data;
    logic                         area_done;

    modport source (
        output valid, write_enable, fb_address, fb_data, area_done,
        input  ready
    );
    modport sink (
        input  valid, write_enable, fb_address, fb_data, area_done,
        output ready
    );
endinterface

FILE: hdl/rpb_coord.sv
`include "assert_macros.svh"

module rpb_coord (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpb_pix_if.sink              i_pix,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rpb_pkg::t_coord      o_coord
);

    logic [rpb_pkg::CNT_W-1:0]          r_col, n_col;
    logic [rpb_pkg::CNT_W-1:0]          r_row, n_row;
    logic                               r_valid, n_valid;
    rpb_pkg::t_coord                    r_stage;
    logic [rpb_pkg::CNT_W-1:0]          col_base, row_base;
    logic signed [rpb_pkg::COORD_W-1:0] left_s, top_s, right_s, bottom_s;
    logic signed [rpb_pkg::COORD_W-1:0] col_s, row_s, x, y;
    logic                               last_col, done, accept;

    assign i_pix.ready = !r_valid || i_ready;
    assign accept      = i_pix.valid && i_pix.ready;

    assign col_base = i_pix.start_of_area ? '0 : r_col;
    assign row_base = i_pix.start_of_area ? '0 : r_row;

    assign left_s   = {{2{i_pix.area_left[11]}}, i_pix.area_left};
    assign top_s    = {{2{i_pix.area_top[11]}}, i_pix.area_top};
    assign right_s  = {{2{i_pix.area_right[11]}}, i_pix.area_right};
    assign bottom_s = {{2{i_pix.area_bottom[11]}}, i_pix.area_bottom};
    assign col_s    = {2'b00, col_base};
    assign row_s    = {2'b00, row_base};

    assign x        = left_s + col_s;
    assign y        = top_s + row_s;
    assign last_col = x >= right_s;
    assign done     = last_col && (y >= bottom_s);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_valid = r_valid;
        if (i_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
            if (done) begin
                n_col = '0;
                n_row = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = row_base + rpb_pkg::CNT_W'(1);
            end else begin
                n_col = col_base + rpb_pkg::CNT_W'(1);
                n_row = row_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage.x     <= x;
            r_stage.y     <= y;
            r_stage.done  <= done;
            r_stage.pixel <= i_pix.pixel_in;
        end
    end

    assign o_valid = r_valid;
    assign o_coord = r_stage;

    `AST_NEXT(a_done_clears, i_clk, i_rst_n, accept && done, r_col == '0 && r_row == '0)
    `AST_NEXT(a_stage_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_stage))

endmodule

FILE: hdl/rpb_map.sv
`include "assert_macros.svh"

module rpb_map #(
    parameter int PHYS_WIDTH  = rpb_pkg::PHYS_WIDTH_DEF,
    parameter int PHYS_HEIGHT = rpb_pkg::PHYS_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rpb_pkg::ROT_W-1:0]  i_rotation,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rpb_pkg::t_coord            i_coord,
    rpb_fb_if.source                   o_fb
);

    localparam int COL_W  = $clog2(PHYS_WIDTH);
    localparam int ROW_W  = $clog2(PHYS_HEIGHT);
    localparam int PROD_W = ROW_W + 14;
    localparam logic signed [rpb_pkg::COORD_W-1:0] W_S   = rpb_pkg::COORD_W'(PHYS_WIDTH);
    localparam logic signed [rpb_pkg::COORD_W-1:0] H_S   = rpb_pkg::COORD_W'(PHYS_HEIGHT);
    localparam logic signed [rpb_pkg::COORD_W-1:0] WM1_S = rpb_pkg::COORD_W'(PHYS_WIDTH - 1);
    localparam logic signed [rpb_pkg::COORD_W-1:0] HM1_S = rpb_pkg::COORD_W'(PHYS_HEIGHT - 1);

    logic signed [rpb_pkg::COORD_W-1:0] pc, pr;
    logic                               en, load;
    logic [PROD_W-1:0]                  addr_full;
    logic                               r_valid;
    logic                               r_we;
    logic [rpb_pkg::ADDR_W-1:0]         r_addr;
    logic [rpb_pkg::PIX_W-1:0]          r_data;
    logic                               r_done;

    always_comb begin
        case (i_rotation)
            rpb_pkg::ROT_0: begin
                pc = i_coord.x;
                pr = i_coord.y;
            end
            rpb_pkg::ROT_90: begin
                pc = i_coord.y;
                pr = HM1_S - i_coord.x;
            end
            rpb_pkg::ROT_180: begin
                pc = WM1_S - i_coord.x;
                pr = HM1_S - i_coord.y;
            end
            rpb_pkg::ROT_270: begin
                pc = WM1_S - i_coord.y;
                pr = i_coord.x;
            end
            default: begin
                pc = i_coord.x;
                pr = i_coord.y;
            end
        endcase
    end

    assign en = (pc >= 0) && (pc < W_S) && (pr >= 0) && (pr < H_S);
    assign addr_full = PROD_W'(pr[ROW_W-1:0]) * PROD_W'(PHYS_WIDTH) + PROD_W'(pc[COL_W-1:0]);

    assign o_ready = !r_valid || o_fb.ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_we   <= en;
            r_addr <= en ? addr_full[rpb_pkg::ADDR_W-1:0] : '0;
            r_data <= {i_coord.pixel[7:0], i_coord.pixel[15:8]};
            r_done <= i_coord.done;
        end
    end

    assign o_fb.valid        = r_valid;
    assign o_fb.write_enable = r_we;
    assign o_fb.fb_address   = r_addr;
    assign o_fb.fb_data      = r_data;
    assign o_fb.area_done    = r_done;

    `AST_IMPL(a_clip_addr, i_clk, i_rst_n, r_valid && !r_we, r_addr == '0)
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, r_valid && !o_fb.ready, r_valid && $stable(r_addr))

endmodule

FILE: hdl/rotating_pixel_blit_core.sv
// Rotating RGB565 blit into a portrait framebuffer.
// Input channel i_pix: one pixel request per item, row-major over the area,
// each carrying the area corners; start_of_area restarts the counters.
// Output channel o_fb: one framebuffer write request per pixel: word address,
// byte-swapped data, write enable (low when clipped) and area_done on the
// last pixel of the area.
// Configuration: i_cfg_we / i_cfg_wdata load the 2-bit rotation register;
// write it only while no requests are in flight.
// Path: the counter stage register, then the mapping stage register, then o_fb.
// Throughput: one request per clock while o_fb.ready is high, set by the single
// counter stage and the single mapping stage (one constant multiply plus add).
// Reset (synchronous, active low): rotation 0, counters zero, both stages
// empty. Output stall: the output register holds; i_pix.ready drops at once
// when the counter stage is full, or after one more request when it is
// empty, and returns with o_fb.ready.
module rotating_pixel_blit_core #(
    parameter int PHYS_WIDTH  = rpb_pkg::PHYS_WIDTH_DEF,
    parameter int PHYS_HEIGHT = rpb_pkg::PHYS_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rpb_pkg::ROT_W-1:0]  i_cfg_wdata,
    rpb_pix_if.sink                    i_pix,
    rpb_fb_if.source                   o_fb
);

    logic [rpb_pkg::ROT_W-1:0] r_rotation;
    logic                      coord_valid;
    logic                      coord_ready;
    rpb_pkg::t_coord           coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= rpb_pkg::ROT_0;
        end else if (i_cfg_we) begin
            r_rotation <= i_cfg_wdata;
        end
    end

    rpb_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_valid (coord_valid),
        .i_ready (coord_ready),
        .o_coord (coord)
    );

    rpb_map #(
        .PHYS_WIDTH  (PHYS_WIDTH),
        .PHYS_HEIGHT (PHYS_HEIGHT)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rotation (r_rotation),
        .i_valid    (coord_valid),
        .o_ready    (coord_ready),
        .i_coord    (coord),
        .o_fb       (o_fb)
    );

endmodule

FILE: tb/testbench.sv
module testbench;

    localparam int PANEL_W     = rpb_pkg::PHYS_WIDTH_DEF;
    localparam int PANEL_H     = rpb_pkg::PHYS_HEIGHT_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_REQS  = 128;
    localparam int NUM_PHASES  = 7;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic                               start;
        logic signed [rpb_pkg::FIELD_W-1:0] left;
        logic signed [rpb_pkg::FIELD_W-1:0] top;
        logic signed [rpb_pkg::FIELD_W-1:0] right;
        logic signed [rpb_pkg::FIELD_W-1:0] bottom;
        logic [rpb_pkg::PIX_W-1:0]          pixel;
    } t_pix_req;

    typedef struct {
        logic                       write_en;
        logic [rpb_pkg::ADDR_W-1:0] addr;
        logic [rpb_pkg::PIX_W-1:0]  data;
        logic                       done;
    } t_fb_write;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [rpb_pkg::ROT_W-1:0] i_cfg_wdata;

    rpb_pix_if pix_bus ();
    rpb_fb_if  fb_bus ();

    rotating_pixel_blit_core #(
        .PHYS_WIDTH  (PANEL_W),
        .PHYS_HEIGHT (PANEL_H)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_bus),
        .o_fb        (fb_bus)
    );

    // predictor state
    logic [rpb_pkg::ROT_W-1:0] rot_cfg = rpb_pkg::ROT_0;
    logic [rpb_pkg::CNT_W-1:0] col_cnt = '0;
    logic [rpb_pkg::CNT_W-1:0] row_cnt = '0;

    t_pix_req  pending_reqs[$];
    t_pix_req  in_flight;
    t_fb_write expected_writes[$];

    bit steady = 1'b0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_clipped = 0;
    int n_area_ends = 0;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_fb_write predict_write(input t_pix_req r);
        int x, y, pc, pr;
        logic row_end, area_end;
        t_fb_write w;
        if (r.start) begin
            col_cnt = '0;
            row_cnt = '0;
        end
        x = int'(r.left) + int'(col_cnt);
        y = int'(r.top) + int'(row_cnt);
        case (rot_cfg)
            rpb_pkg::ROT_90: begin
                pc = y;
                pr = PANEL_H - 1 - x;
            end
            rpb_pkg::ROT_180: begin
                pc = PANEL_W - 1 - x;
                pr = PANEL_H - 1 - y;
            end
            rpb_pkg::ROT_270: begin
                pc = PANEL_W - 1 - y;
                pr = x;
            end
            default: begin
                pc = x;
                pr = y;
            end
        endcase
        w.write_en = pc >= 0 && pc < PANEL_W && pr >= 0 && pr < PANEL_H;
        w.addr = w.write_en ? rpb_pkg::ADDR_W'(pr * PANEL_W + pc) : '0;
        w.data = {r.pixel[7:0], r.pixel[15:8]};
        row_end = x >= int'(r.right);
        area_end = row_end && y >= int'(r.bottom);
        w.done = area_end;
        if (area_end) begin
            col_cnt = '0;
            row_cnt = '0;
        end else if (row_end) begin
            col_cnt = '0;
            row_cnt = row_cnt + rpb_pkg::CNT_W'(1);
        end else begin
            col_cnt = col_cnt + rpb_pkg::CNT_W'(1);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("mismatch at write %0d: %s got 0x%0h expected 0x%0h",
                     n_results, what, got, want);
    endtask

    task automatic add_req(input logic s, input int l, input int t, input int r, input int b,
                           input logic [rpb_pkg::PIX_W-1:0] px);
        t_pix_req q;
        q.start  = s;
        q.left   = rpb_pkg::FIELD_W'(l);
        q.top    = rpb_pkg::FIELD_W'(t);
        q.right  = rpb_pkg::FIELD_W'(r);
        q.bottom = rpb_pkg::FIELD_W'(b);
        q.pixel  = px;
        pending_reqs.push_back(q);
    endtask

    // row-major pixels of an area, cut off after max_px
    task automatic add_area(input logic s, input int l, input int t, input int r, input int b,
                            input int max_px);
        int n;
        n = 0;
        for (int y = t; y <= b; y++) begin
            for (int x = l; x <= r; x++) begin
                if (n < max_px) begin
                    add_req(s && n == 0, l, t, r, b, rpb_pkg::PIX_W'($urandom));
                    n++;
                end
            end
        end
    endtask

    task automatic queue_random(input int n_reqs, input int lw, input int lh);
        int added, kind, l, t, w, h, cap;
        added = 0;
        while (added < n_reqs) begin
            kind = $urandom_range(99);
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            if (kind < 8) begin
                // loose request: any corners, any start
                add_req(1'($urandom_range(1)), int'($urandom_range(4095)) - 2048,
                        int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                        int'($urandom_range(4095)) - 2048, rpb_pkg::PIX_W'($urandom));
                added++;
            end else begin
                if (kind < 20) begin
                    l = int'($urandom_range(4095)) - 2048;
                    t = int'($urandom_range(4095)) - 2048;
                    if (l > 2048 - w)
                        l = 2048 - w;
                    if (t > 2048 - h)
                        t = 2048 - h;
                end else begin
                    l = int'($urandom_range(lw + 11)) - 8;
                    t = int'($urandom_range(lh + 9)) - 6;
                end
                cap = (kind >= 8 && kind < 14) ? $urandom_range(1, w * h) : w * h;
                add_area($urandom_range(9) != 0, l, t, l + w - 1, t + h - 1, cap);
                added += cap;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || pix_bus.valid || expected_writes.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_rotation(input logic [rpb_pkg::ROT_W-1:0] rot);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rot;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rot_cfg = rot;
        @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid         <= 1'b0;
            pix_bus.start_of_area <= 1'b0;
            pix_bus.area_left     <= '0;
            pix_bus.area_top      <= '0;
            pix_bus.area_right    <= '0;
            pix_bus.area_bottom   <= '0;
            pix_bus.pixel_in      <= '0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                expected_writes.push_back(predict_write(in_flight));
                n_accepted++;
            end
            if (!pix_bus.valid || pix_bus.ready) begin
                if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                    in_flight = pending_reqs.pop_front();
                    pix_bus.valid         <= 1'b1;
                    pix_bus.start_of_area <= in_flight.start;
                    pix_bus.area_left     <= in_flight.left;
                    pix_bus.area_top      <= in_flight.top;
                    pix_bus.area_right    <= in_flight.right;
                    pix_bus.area_bottom   <= in_flight.bottom;
                    pix_bus.pixel_in      <= in_flight.pixel;
                end else begin
                    pix_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            fb_bus.ready <= 1'b0;
        else
            fb_bus.ready <= steady || $urandom_range(99) >= 20;
    end

    // write monitor
    always @(posedge i_clk) begin : fb_monitor
        t_fb_write want;
        if (i_rst_n && fb_bus.valid && fb_bus.ready) begin
            n_results++;
            if (expected_writes.size() == 0) begin
                report_mismatch("write with nothing pending, addr", 32'(fb_bus.fb_address),
                                32'(0));
            end else begin
                want = expected_writes.pop_front();
                if (!want.write_en)
                    n_clipped++;
                if (want.done)
                    n_area_ends++;
                if (fb_bus.write_enable !== want.write_en)
                    report_mismatch("write_enable", 32'(fb_bus.write_enable),
                                    32'(want.write_en));
                if (fb_bus.fb_address !== want.addr)
                    report_mismatch("fb_address", 32'(fb_bus.fb_address), 32'(want.addr));
                if (fb_bus.fb_data !== want.data)
                    report_mismatch("fb_data", 32'(fb_bus.fb_data), 32'(want.data));
                if (fb_bus.area_done !== want.done)
                    report_mismatch("area_done", 32'(fb_bus.area_done), 32'(want.done));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_bus.valid && pix_bus.ready) || (fb_bus.valid && fb_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stalled for %0d cycles with %0d writes outstanding",
                     quiet_cycles, expected_writes.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [rpb_pkg::ROT_W-1:0] rot_plan[NUM_PHASES];
        rot_plan = '{rpb_pkg::ROT_90, rpb_pkg::ROT_180, rpb_pkg::ROT_270, rpb_pkg::ROT_0,
                     rpb_pkg::ROT_270, rpb_pkg::ROT_90, rpb_pkg::ROT_180};

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= rpb_pkg::ROT_0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, rotation at reset value
        add_req(1'b1, -2048, -2048, -2048, -2048, 16'h0000);
        add_req(1'b1, 2047, 2047, 2047, 2047, 16'hFFFF);
        add_req(1'b1, 0, 0, 0, 0, 16'h00FF);
        add_req(1'b1, PANEL_W - 1, PANEL_H - 1, PANEL_W - 1, PANEL_H - 1, 16'hFF00);
        add_req(1'b1, PANEL_W, 0, PANEL_W, 0, 16'h1234);
        add_req(1'b1, 0, PANEL_H, 0, PANEL_H, 16'hA55A);
        add_req(1'b1, -1, -1, -1, -1, 16'h5AA5);
        // 2x2 straddling the bottom-right corner
        add_area(1'b1, PANEL_W - 1, PANEL_H - 1, PANEL_W, PANEL_H, 4);
        // right < left: each pixel ends its row
        add_req(1'b1, 10, 3, 5, 5, 16'h0F0F);
        add_req(1'b0, 10, 3, 5, 5, 16'hF0F0);
        add_req(1'b0, 10, 3, 5, 5, 16'h3C3C);
        // bottom < top
        add_req(1'b1, 2, 9, 1, 0, 16'hC3C3);
        // area cut short, then a fresh one
        add_area(1'b1, 0, 0, 2, 2, 2);
        add_area(1'b1, 100, 200, 101, 200, 2);
        // alternating corner bits
        add_req(1'b1, -1366, 1365, 1365, -1366, 16'h5555);
        add_req(1'b0, 1365, -1366, -1366, 1365, 16'hAAAA);
        add_req(1'b0, 7, 11, 8, 11, 16'h8001);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            steady = (p == 4);
            write_rotation(rot_plan[p]);
            if (rot_plan[p] == rpb_pkg::ROT_90 || rot_plan[p] == rpb_pkg::ROT_270)
                queue_random(PHASE_REQS, PANEL_H, PANEL_W);
            else
                queue_random(PHASE_REQS, PANEL_W, PANEL_H);
            wait_drained();
        end
        steady = 1'b0;
        repeat (4) @(posedge i_clk);

        if (expected_writes.size() != 0)
            report_mismatch("writes never seen", 32'(expected_writes.size()), 32'(0));
        $display("blit run: %0d pixel requests, %0d writes checked under all four rotations",
                 n_accepted, n_results);
        $display("          %0d clipped writes, %0d area ends", n_clipped, n_area_ends);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
